/* hw/rtl/b64sc_pkg.sv */
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and helpers of the Base64 stream codec
// Holds the group job passed from the front to the back and the alphabet
// translation functions.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sc_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;  // '9'
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='

  // One finished group. For encoding, nsym is the number of real characters
  // (two to four, the rest are padding); for decoding it is the byte count.
  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  nsym;
    logic        enc;
    logic        bad;
  } job_t;

  typedef struct packed {
    logic [5:0] val;
    logic       bad;
  } char_val_t;

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return CHAR_UPPER_A + v8;
    end else if (v < 6'd52) begin
      return CHAR_LOWER_A + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      return CHAR_DIGIT_0 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

  function automatic char_val_t char_value(input logic [7:0] c);
    char_val_t  r;
    logic [7:0] d;
    r = '0;
    d = 8'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A + 8'd26;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0 + 8'd52;
    end else if (c == CHAR_PLUS) begin
      d = 8'd62;
    end else if (c == CHAR_SLASH) begin
      d = 8'd63;
    end else begin
      r.bad = 1'b1;
    end
    r.val = d[5:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64sc_ifs.sv */
// ----------------------------------------------------------------------------
// b64sc_ifs: channel interfaces of the Base64 stream codec
// Input item channel, result channel and mode write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_char;
  modport source (output valid, output out_byte, output out_last, output bad_char,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input bad_char,
                  output ready);
endinterface

interface b64sc_cfg_if;
  logic valid;
  logic ready;
  logic decode_mode;
  modport source (output valid, output decode_mode, input ready);
  modport sink   (input valid, input decode_mode, output ready);
endinterface

`default_nettype wire

/* hw/rtl/b64sc_front.sv */
// ----------------------------------------------------------------------------
// b64sc_front: input side of the Base64 stream codec
// Holds the mode register and the partial group, and issues a job for each
// group that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_front (
  input  wire               clk,
  input  wire               rst,
  b64sc_in_if.sink          in_ch,
  b64sc_cfg_if.sink         cfg,
  output b64sc_pkg::job_t   push_job,
  output logic              push_valid,
  input  wire               push_ready
);
  import b64sc_pkg::*;

  logic        decode_mode;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_count;
  logic        group_error;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [1:0]  pad_count_next;
  logic        group_error_next;

  logic        accept;
  logic        enc_full;
  logic [1:0]  enc_cnt;
  logic [23:0] enc_bits;
  char_val_t   cv;
  logic        pad_hit;
  logic        dec_bad;
  logic [5:0]  dec_val;
  logic [1:0]  pad_new;
  logic        err_new;
  logic [23:0] dec_bits;
  logic [2:0]  nbytes;
  logic        dec_done;

  // An item is taken only when the queue can hold whatever job it makes.
  assign in_ch.ready = push_ready;
  assign cfg.ready   = 1'b1;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    enc_bits = {group_bits[15:0], in_ch.in_byte};
    enc_cnt  = group_count + 2'd1;
    enc_full = (enc_cnt == 2'd3);

    cv       = char_value(in_ch.in_byte);
    pad_hit  = (in_ch.in_byte == CHAR_PAD);
    dec_bad  = !pad_hit && cv.bad;
    dec_val  = pad_hit ? 6'd0 : cv.val;
    pad_new  = (pad_hit && pad_count != 2'd3) ? pad_count + 2'd1 : pad_count;
    err_new  = group_error | dec_bad;
    dec_bits = {group_bits[17:0], dec_val};
    dec_done = (group_count == 2'd3);
    nbytes   = 3'd3 - {1'b0, pad_new};

    push_job = '0;
    if (!decode_mode) begin
      push_job.enc = 1'b1;
      if (enc_full) begin
        push_job.bits = enc_bits;
        push_job.nsym = 3'd4;
      end else if (enc_cnt == 2'd2) begin
        push_job.bits = {enc_bits[15:0], 8'd0};
        push_job.nsym = 3'd3;
      end else begin
        push_job.bits = {enc_bits[7:0], 16'd0};
        push_job.nsym = 3'd2;
      end
      push_valid = accept && (enc_full || in_ch.in_last);
    end else begin
      push_job.bits = dec_bits;
      push_job.nsym = nbytes;
      push_job.bad  = err_new;
      push_valid    = accept && dec_done && (nbytes != 3'd0);
    end

    if (!decode_mode) begin
      group_bits_next  = enc_bits;
      group_count_next = enc_cnt;
      pad_count_next   = 2'd0;
      group_error_next = 1'b0;
      if (enc_full) begin
        group_bits_next  = '0;
        group_count_next = 2'd0;
      end
    end else begin
      group_bits_next  = dec_bits;
      group_count_next = group_count + 2'd1;
      pad_count_next   = pad_new;
      group_error_next = err_new;
      if (dec_done) begin
        group_bits_next  = '0;
        group_count_next = 2'd0;
        pad_count_next   = 2'd0;
        group_error_next = 1'b0;
      end
    end
    if (in_ch.in_last) begin
      group_bits_next  = '0;
      group_count_next = 2'd0;
      pad_count_next   = 2'd0;
      group_error_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group_bits  <= '0;
      group_count <= 2'd0;
      pad_count   <= 2'd0;
      group_error <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      // A mode write drops any partial group.
      decode_mode <= cfg.decode_mode;
      group_bits  <= '0;
      group_count <= 2'd0;
      pad_count   <= 2'd0;
      group_error <= 1'b0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_count   <= pad_count_next;
      group_error <= group_error_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/b64sc_fifo.sv */
// ----------------------------------------------------------------------------
// b64sc_fifo: job queue of the Base64 stream codec
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_fifo #(
  parameter int DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst,
  input  b64sc_pkg::job_t  push_job,
  input  wire              push_valid,
  output logic             push_ready,
  output b64sc_pkg::job_t  pop_job,
  output logic             pop_valid,
  input  wire              pop_ready
);
  import b64sc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/b64sc_back.sv */
// ----------------------------------------------------------------------------
// b64sc_back: output side of the Base64 stream codec
// Takes one job at a time and sends its characters or bytes one per cycle
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sc_back (
  input  wire              clk,
  input  wire              rst,
  input  b64sc_pkg::job_t  pop_job,
  input  wire              pop_valid,
  output logic             pop_ready,
  b64sc_out_if.source      out_ch
);
  import b64sc_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] beat;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_char;

  logic       advance;
  logic       beat_last;
  logic [5:0] sel6;
  logic [7:0] sel8;
  logic [7:0] beat_byte;

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.out_last = out_last;
  assign out_ch.bad_char = bad_char;

  assign advance   = busy && (!out_valid || out_ch.ready);
  assign pop_ready = !busy || (advance && beat_last);

  always_comb begin
    case (beat)
      2'd0:    sel6 = cur.bits[23:18];
      2'd1:    sel6 = cur.bits[17:12];
      2'd2:    sel6 = cur.bits[11:6];
      default: sel6 = cur.bits[5:0];
    endcase
    case (beat)
      2'd0:    sel8 = cur.bits[23:16];
      2'd1:    sel8 = cur.bits[15:8];
      default: sel8 = cur.bits[7:0];
    endcase
    if (cur.enc) begin
      beat_byte = ({1'b0, beat} < cur.nsym) ? sym_char(sel6) : CHAR_PAD;
      beat_last = (beat == 2'd3);
    end else begin
      beat_byte = sel8;
      beat_last = (({1'b0, beat} + 3'd1) == cur.nsym);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= beat_byte;
      out_last <= beat_last;
      bad_char <= cur.bad && !cur.enc;
    end
    if (pop_valid && pop_ready) begin
      cur <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      beat      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // A new job restarts the beat count, also on the edge that sends the
      // last beat of the previous job.
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
        beat <= 2'd0;
      end else begin
        if (advance) begin
          beat <= beat + 2'd1;
        end
        if (advance && beat_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_codec_core.sv */
// ----------------------------------------------------------------------------
// base64_stream_codec_core: streaming Base64 codec, standard alphabet
// Encodes bytes to characters or decodes characters to bytes, as chosen by
// the mode register.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                        transaction when
//   -------  ---------  -----------------------------  -------------------
//   in_ch    in         in_byte[7:0], in_last          valid && ready
//   out_ch   out        out_byte[7:0], out_last,       valid && ready
//                       bad_char
//   cfg      in         decode_mode                    valid && ready
//
// The front takes one input transaction per cycle whenever the job queue has
// room, so a full queue is the only thing that stalls the input.
// The back serializes a job at one result per cycle while the output is not
// stalled: four characters per three bytes when encoding, so the back limits
// the encoding input; decoding then sustains one character per cycle.
// An input's job passes the queue, the job register and the output register.
// Reset (rst, synchronous) selects encoding and empties every group, queue
// and output register; the config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire          clk,
  input  wire          rst,
  b64sc_in_if.sink     in_ch,
  b64sc_out_if.source  out_ch,
  b64sc_cfg_if.sink    cfg
);
  import b64sc_pkg::*;

  // Jobs flow front -> queue -> back. A job is one finished group, with the
  // gathered bits already aligned so the back only selects slices.
  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  b64sc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // The queue lets the front keep gathering while the back waits on a
  // stalled output.
  b64sc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  b64sc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // The front accepts only with room in the queue, so a job is never dropped.
  assert property (@(posedge clk) disable iff (rst) push_valid |-> push_ready)
    else $error("job issued while queue full");

  // Encode jobs carry two to four real characters, decode jobs one to three.
  assert property (@(posedge clk) disable iff (rst)
      push_valid |-> ((push_job.enc && push_job.nsym >= 3'd2 && push_job.nsym <= 3'd4) ||
                      (!push_job.enc && push_job.nsym >= 3'd1 && push_job.nsym <= 3'd3)))
    else $error("job symbol count out of range");

  // Encoding never flags a bad character.
  assert property (@(posedge clk) disable iff (rst)
      push_valid && push_job.enc |-> !push_job.bad)
    else $error("encode job marked bad");

  // The input is held off exactly when the queue is full.
  assert property (@(posedge clk) disable iff (rst)
      !push_ready |-> !in_ch.ready)
    else $error("input ready while queue full");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_base64_stream_codec_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_codec_core: self-checking testbench of the Base64 codec
// A queue of pending steps feeds a clocked driver that sends input
// transactions and mode writes. A clocked monitor predicts the results of
// every accepted transaction and checks each result transaction against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_base64_stream_codec_core;
  import b64sc_pkg::*;

  // The run is far shorter than this. Hitting it means the block hung.
  localparam int CYCLE_LIMIT  = 200000;
  // Quiet cycles before a mode write or at the end. These cover the queue,
  // the job and output registers, even after an item with no result.
  localparam int DRAIN_QUIET  = 8;
  localparam int END_QUIET    = 16;
  localparam int TOTAL_ITEMS  = 260;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // One entry of the stimulus queue. A drain step holds the feed until every
  // predicted result has come back and the block has gone quiet.
  typedef enum logic [1:0] {
    STEP_BYTE,
    STEP_MODE,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [7:0]  data;
    logic        last;
    int unsigned wait_cycles;
  } step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } b64_result_t;

  logic clk;
  logic rst;

  b64sc_in_if  in_ch();
  b64sc_out_if out_ch();
  b64sc_cfg_if cfg_ch();

  base64_stream_codec_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  step_t       pending[$];
  b64_result_t expected_q[$];
  int          mismatches  = 0;
  int          stim_items  = 0;
  int          quiet_cycles;
  int          cycle_count = 0;
  logic        send_idling = 1'b1;

  // Predictor state, a private copy of what the block should hold.
  logic        codec_mode;
  logic [23:0] grp_bits;
  logic [1:0]  grp_count;
  logic [1:0]  grp_pads;
  logic        grp_err;

  // Driver and sink bookkeeping.
  int          gap_left = -1;
  int          stall_left;
  int          calm_left;
  logic        sink_calm;

  // --------------------------------------------------------------------------
  // Alphabet helpers
  // --------------------------------------------------------------------------

  // Maps a six-bit value onto its character of the standard alphabet.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    if (v <= 6'd25) return CHAR_UPPER_A + {2'b00, v};
    if (v <= 6'd51) return CHAR_LOWER_A + {2'b00, v} - 8'd26;
    if (v <= 6'd61) return CHAR_DIGIT_0 + {2'b00, v} - 8'd52;
    return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
  endfunction

  // Returns {bad, value}. A character outside the alphabet reads as zero.
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A + 8'd26;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0 + 8'd52;
    end else if (c == CHAR_PLUS) begin
      d = 8'd62;
    end else if (c == CHAR_SLASH) begin
      d = 8'd63;
    end else begin
      return 7'b1_000000;
    end
    return {1'b0, d[5:0]};
  endfunction

  // --------------------------------------------------------------------------
  // Queue helpers
  // --------------------------------------------------------------------------

  task automatic add_expected(input b64_result_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic add_step(input step_t s);
    pending.insert(pending.size(), s);
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  task automatic clear_group();
    grp_bits  = '0;
    grp_count = '0;
    grp_pads  = '0;
    grp_err   = 1'b0;
  endtask

  // Works out the results that one accepted input transaction causes and
  // appends them to the expected queue.
  task automatic predict_codec(input logic [7:0] c, input logic fin);
    logic [6:0]  lut;
    logic [5:0]  v;
    logic [23:0] aligned;
    logic [7:0]  ch;
    int          nchars;
    int          nbytes;
    if (codec_mode == MODE_ENCODE) begin
      grp_bits  = {grp_bits[15:0], c};
      grp_count = grp_count + 2'd1;
      if (grp_count == 2'd3) begin
        // A full group of three bytes always gives four characters.
        for (int i = 0; i < 4; i++) begin
          add_expected('{sextet_to_char(grp_bits[23 - 6 * i -: 6]), i == 3, 1'b0});
        end
        clear_group();
      end else if (fin) begin
        // A short final group is left-aligned and padded out with '='.
        nchars  = grp_count + 1;
        aligned = (grp_count == 2'd1) ? {grp_bits[7:0], 16'h0} : {grp_bits[15:0], 8'h0};
        for (int i = 0; i < 4; i++) begin
          ch = (i < nchars) ? sextet_to_char(aligned[23 - 6 * i -: 6]) : CHAR_PAD;
          add_expected('{ch, i == 3, 1'b0});
        end
        clear_group();
      end
    end else begin
      lut = char_to_sextet(c);
      v   = lut[5:0];
      // A pad counts as zero wherever it sits, and the pad count stops at 3.
      if (c == CHAR_PAD) begin
        v      = 6'd0;
        lut[6] = 1'b0;
        if (grp_pads != 2'd3) grp_pads = grp_pads + 2'd1;
      end
      if (lut[6]) grp_err = 1'b1;
      grp_bits = {grp_bits[17:0], v};
      if (grp_count == 2'd3) begin
        nbytes = 3 - grp_pads;
        for (int i = 0; i < nbytes; i++) begin
          add_expected('{grp_bits[23 - 8 * i -: 8], (i + 1) == nbytes, grp_err});
        end
        clear_group();
      end else begin
        grp_count = grp_count + 2'd1;
      end
    end
    // The end of a message drops whatever partial group is left.
    if (fin) clear_group();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] data, input logic fin);
    add_step('{STEP_BYTE, data, fin, send_idling ? $urandom_range(0, 6) : 0});
    stim_items++;
  endtask

  task automatic push_drain();
    add_step('{STEP_DRAIN, 8'h00, 1'b0, 0});
  endtask

  // A mode write is only legal with the block idle, so a drain goes first.
  task automatic push_mode(input logic mode);
    push_drain();
    add_step('{STEP_MODE, {7'd0, mode}, 1'b0, 0});
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and the watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every input of the block is at a known value from time zero.
  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.in_last      = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.decode_mode = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: sends the pending steps. It only moves on once the current
  // transaction has been taken, and valid gets exactly one assignment per edge
  // so a back-to-back transaction keeps it high.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : feed
    logic next_in_valid;
    logic next_cfg_valid;
    next_in_valid  = 1'b0;
    next_cfg_valid = 1'b0;
    if (rst) begin
      in_ch.valid        <= 1'b0;
      in_ch.in_byte      <= 8'h00;
      in_ch.in_last      <= 1'b0;
      cfg_ch.valid       <= 1'b0;
      cfg_ch.decode_mode <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready) && !(cfg_ch.valid && !cfg_ch.ready)) begin
      if (pending.size() != 0) begin
        case (pending[0].kind)
          STEP_BYTE: begin
            // The idle gap in front of each byte is drawn when the byte is queued and
            // counted down once it reaches the head of the queue.
            if (gap_left < 0) gap_left = pending[0].wait_cycles;
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              gap_left = -1;
              next_in_valid = 1'b1;
              in_ch.in_byte <= pending[0].data;
              in_ch.in_last <= pending[0].last;
              void'(pending.pop_front());
            end
          end
          STEP_MODE: begin
            next_cfg_valid = 1'b1;
            cfg_ch.decode_mode <= pending[0].data[0];
            void'(pending.pop_front());
          end
          STEP_DRAIN: begin
            // A byte taken on this very edge is not counted yet, so wait
            // until the input side has gone idle.
            if (!in_ch.valid && quiet_cycles >= DRAIN_QUIET) void'(pending.pop_front());
          end
          default: begin
            void'(pending.pop_front());
          end
        endcase
      end
      in_ch.valid  <= next_in_valid;
      cfg_ch.valid <= next_cfg_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: stalls a random number of cycles after each result, with
  // calm stretches in which it never stalls.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
      sink_calm  = 1'b0;
    end else begin
      if (calm_left == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 250);
      end else begin
        calm_left--;
      end
      if (out_ch.valid && out_ch.ready) stall_left = sink_calm ? 0 : $urandom_range(0, 6);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: follows the mode writes, predicts on every accepted input
  // transaction and checks every result transaction. The quiet counter is
  // updated with a nonblocking assignment so the driver and the end of the
  // run always see the value from before the edge.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin : watch
    b64_result_t want;
    if (rst) begin
      codec_mode = MODE_ENCODE;
      clear_group();
      expected_q.delete();
      quiet_cycles <= 0;
    end else begin
      // A mode write throws away any partial group.
      if (cfg_ch.valid && cfg_ch.ready) begin
        codec_mode = cfg_ch.decode_mode;
        clear_group();
      end
      if (in_ch.valid && in_ch.ready) predict_codec(in_ch.in_byte, in_ch.in_last);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %h last %b bad %b",
                   $time, out_ch.out_byte, out_ch.out_last, out_ch.bad_char);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.data, out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.out_last !== want.last) begin
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.last, out_ch.out_last);
            mismatches++;
          end
          if (out_ch.bad_char !== want.bad) begin
            $display("%0t: bad_char mismatch: expected %b, actual %b",
                     $time, want.bad, out_ch.bad_char);
            mismatches++;
          end
        end
      end
      quiet_cycles <= (expected_q.size() == 0 && !out_ch.valid) ? quiet_cycles + 1 : 0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int   phase_end;
    int   msg_len;
    int   groups;
    int   pads;
    int   bad_pos;
    logic cur_mode;
    logic msg_fin;
    logic [7:0] ch;

    // Directed encoding: a full group that is also the last one, a one-byte
    // and a two-byte final group, then a byte left behind in a partial group
    // that the following mode write has to discard.
    send_idling = 1'b1;
    push_mode(MODE_ENCODE);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h55, 1'b0);

    // Directed decoding: a plain group, pads in the middle of a group, a group
    // of only pads, characters outside the alphabet at both byte extremes, and
    // a message that stops short of a full group.
    push_mode(MODE_DECODE);
    push_byte("T", 1'b0);
    push_byte("W", 1'b0);
    push_byte("F", 1'b0);
    push_byte("u", 1'b0);
    push_byte("Q", 1'b0);
    push_byte("=", 1'b0);
    push_byte("9", 1'b0);
    push_byte("=", 1'b0);
    repeat (4) push_byte("=", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte("*", 1'b0);
    push_byte("9", 1'b0);
    push_byte("a", 1'b0);
    push_byte("b", 1'b1);

    // Random phases, each opened by a mode write. The mode mostly flips.
    cur_mode = MODE_DECODE;
    while (stim_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 3) != 0) cur_mode = ~cur_mode;
      push_mode(cur_mode);
      send_idling = ($urandom_range(0, 2) != 0);
      phase_end   = stim_items + $urandom_range(25, 55);
      if (phase_end > TOTAL_ITEMS) phase_end = TOTAL_ITEMS;
      while (stim_items < phase_end) begin
        if (cur_mode == MODE_ENCODE) begin
          // Random bytes; now and then a message runs on without an end mark.
          msg_len = $urandom_range(1, 9);
          msg_fin = ($urandom_range(0, 7) != 0);
          for (int k = 0; k < msg_len; k++) begin
            push_byte(8'($urandom_range(0, 255)), msg_fin && k == msg_len - 1);
          end
        end else if ($urandom_range(0, 7) == 0) begin
          // Noise: any byte at all.
          msg_len = $urandom_range(1, 9);
          for (int k = 0; k < msg_len; k++) begin
            push_byte(8'($urandom_range(0, 255)), k == msg_len - 1);
          end
        end else begin
          // Well-formed text with random content, sometimes broken by a stray
          // character or cut short before the final group is complete.
          groups  = $urandom_range(1, 3);
          pads    = $urandom_range(0, 2);
          msg_len = groups * 4;
          bad_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, msg_len - 1) : -1;
          msg_fin = ($urandom_range(0, 7) != 0);
          if ($urandom_range(0, 7) == 0) msg_len = msg_len - $urandom_range(1, 3);
          for (int k = 0; k < msg_len; k++) begin
            if (k == bad_pos) begin
              ch = 8'($urandom_range(0, 255));
            end else if (k >= groups * 4 - pads) begin
              ch = CHAR_PAD;
            end else begin
              ch = sextet_to_char(6'($urandom_range(0, 63)));
            end
            push_byte(ch, msg_fin && k == msg_len - 1);
          end
        end
        // Every so often the feed holds until all results are back.
        if ($urandom_range(0, 9) == 0) push_drain();
      end
    end
    // Ending on a drain means the queue only runs dry once nothing is in
    // flight, so the wait below cannot finish early.
    push_drain();

    wait (rst == 1'b0);
    while (pending.size() != 0 || in_ch.valid || cfg_ch.valid || quiet_cycles < END_QUIET) begin
      @(posedge clk);
    end
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/b64sc_pkg.sv
hw/rtl/b64sc_ifs.sv
hw/rtl/b64sc_front.sv
hw/rtl/b64sc_fifo.sv
hw/rtl/b64sc_back.sv
hw/rtl/base64_stream_codec_core.sv
tb/sv/tb_base64_stream_codec_core.sv
